FILE: hdl/sqvt_pkg.sv
// Shared widths, constants, stage payload type and sine table builder for the vertex transform.
package sqvt_pkg;

    localparam int ANGLE_W = 16;
    localparam int SCALE_W = 16;
    localparam int COORD_W = 24;
    localparam int DIM_W   = 12;
    localparam int PIVOT_W = 17;
    localparam int TRIG_W  = 17;   // signed Q1.15, -1.0 .. +1.0
    localparam int MAG_W   = 16;   // table entry, 0 .. 32768
    localparam int BASE_W  = 28;   // unsigned corner-0 offset, Q.16 pixels
    localparam int OFS_W   = 29;   // signed corner offset
    localparam int ROT_W   = 46;   // rotated offset, trig * offset
    localparam int SPLIT_W = 23;   // low slice of the rotated offset for the scale multiply
    localparam int SUM_W   = 64;
    localparam int SHR_W   = 40;   // scaled value after rounding shift
    localparam int VSUM_W  = 41;   // scaled value plus position

    localparam logic [PIVOT_W-1:0] PIVOT_ONE   = 17'd65536;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;

    localparam logic signed [VSUM_W-1:0] COORD_MAX = 41'sd8388607;
    localparam logic signed [VSUM_W-1:0] COORD_MIN = -41'sd8388608;

    localparam longint K1 = 64'sd1686629713;
    localparam longint K3 = 64'sd693598665;
    localparam longint K5 = 64'sd85569310;
    localparam longint K7 = 64'sd5026994;
    localparam longint K9 = 64'sd172271;

    typedef struct packed {
        logic [1:0]                 corner;
        logic                       last;
        logic signed [TRIG_W-1:0]   cos_val;
        logic signed [TRIG_W-1:0]   sin_val;
        logic signed [OFS_W-1:0]    ofs_x;
        logic signed [OFS_W-1:0]    ofs_y;
        logic [SCALE_W-1:0]         scale_x;
        logic [SCALE_W-1:0]         scale_y;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
    } corner_t;

    // Q30 odd polynomial of sin(pi/2 * t), rounded to Q15 and clamped to 0..1.0
    function automatic logic [MAG_W-1:0] sine_q15(input longint t);
        longint t2;
        longint p;
        longint r;
        t2 = (t * t) >>> 30;
        p  = K9;
        p  = -K7 + ((p * t2) >>> 30);
        p  =  K5 + ((p * t2) >>> 30);
        p  = -K3 + ((p * t2) >>> 30);
        p  =  K1 + ((p * t2) >>> 30);
        r  = (t * p) >>> 30;
        r  = (r + 64'sd16384) >>> 15;
        if (r < 0) begin
            r = 0;
        end
        if (r > 32768) begin
            r = 32768;
        end
        return r[MAG_W-1:0];
    endfunction

endpackage

FILE: hdl/sqvt_sine_rom.sv
// Quarter-wave sine table with two registered lookups giving cos(-angle) and sin(-angle).
module sqvt_sine_rom #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic [sqvt_pkg::ANGLE_W-1:0]         angle,
    output logic signed [sqvt_pkg::TRIG_W-1:0]   cos_val,
    output logic signed [sqvt_pkg::TRIG_W-1:0]   sin_val
);

    localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PW = AW + 14;

    logic [sqvt_pkg::MAG_W-1:0] tbl [SINE_TABLE_DEPTH+1];

    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_tbl
        localparam longint TPOS = (longint'(g) <<< 30) / SINE_TABLE_DEPTH;
        assign tbl[g] = sqvt_pkg::sine_q15(TPOS);
    end

    logic [sqvt_pkg::ANGLE_W-1:0] ang_c;
    logic [PW-1:0]                pc_full;
    logic [PW-1:0]                ps_full;
    logic [AW-1:0]                idx_c;
    logic [AW-1:0]                idx_s;

    logic [sqvt_pkg::MAG_W-1:0]   cmag_reg;
    logic [sqvt_pkg::MAG_W-1:0]   smag_reg;
    logic                         cneg_reg;
    logic                         sneg_reg;

    assign ang_c = angle + sqvt_pkg::QUARTER_TURN;

    always_comb begin
        pc_full = PW'(ang_c[13:0]) * PW'(SINE_TABLE_DEPTH);
        ps_full = PW'(angle[13:0]) * PW'(SINE_TABLE_DEPTH);
        // odd quadrants read the table backward
        idx_c = ang_c[14] ? AW'(SINE_TABLE_DEPTH) - pc_full[PW-1:14] : pc_full[PW-1:14];
        idx_s = angle[14] ? AW'(SINE_TABLE_DEPTH) - ps_full[PW-1:14] : ps_full[PW-1:14];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cmag_reg <= tbl[idx_c];
            smag_reg <= tbl[idx_s];
            cneg_reg <= ang_c[15];
            // s is the negated lookup, so the lower half-turn comes out negative
            sneg_reg <= !angle[15];
        end
    end

    always_comb begin
        cos_val = cneg_reg ? -$signed({1'b0, cmag_reg}) : $signed({1'b0, cmag_reg});
        sin_val = sneg_reg ? -$signed({1'b0, smag_reg}) : $signed({1'b0, smag_reg});
    end

endmodule

FILE: hdl/sqvt_issue.sv
// Sprite holding register and corner sequencer feeding one corner per cycle into the pipeline while en is high.
module sqvt_issue #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [sqvt_pkg::ANGLE_W-1:0]         s_angle,
    input  logic [sqvt_pkg::SCALE_W-1:0]         s_scale_x,
    input  logic [sqvt_pkg::SCALE_W-1:0]         s_scale_y,
    input  logic signed [sqvt_pkg::COORD_W-1:0]  s_position_x,
    input  logic signed [sqvt_pkg::COORD_W-1:0]  s_position_y,
    input  logic [sqvt_pkg::DIM_W-1:0]           width,
    input  logic [sqvt_pkg::DIM_W-1:0]           height,
    input  logic [sqvt_pkg::BASE_W-1:0]          base_x,
    input  logic [sqvt_pkg::BASE_W-1:0]          base_y,
    output logic                                 p1_valid,
    output sqvt_pkg::corner_t                    p1_data
);

    localparam logic [1:0] LAST_CORNER = 2'd3;

    logic                                 hold_valid_reg;
    logic [1:0]                           count_reg;
    logic [sqvt_pkg::ANGLE_W-1:0]         angle_reg;
    logic [sqvt_pkg::SCALE_W-1:0]         sx_reg;
    logic [sqvt_pkg::SCALE_W-1:0]         sy_reg;
    logic signed [sqvt_pkg::COORD_W-1:0]  px_reg;
    logic signed [sqvt_pkg::COORD_W-1:0]  py_reg;

    logic                                 p1_valid_reg;
    logic [1:0]                           p1_corner_reg;
    logic                                 p1_last_reg;
    logic signed [sqvt_pkg::OFS_W-1:0]    p1_ox_reg;
    logic signed [sqvt_pkg::OFS_W-1:0]    p1_oy_reg;
    logic [sqvt_pkg::SCALE_W-1:0]         p1_sx_reg;
    logic [sqvt_pkg::SCALE_W-1:0]         p1_sy_reg;
    logic signed [sqvt_pkg::COORD_W-1:0]  p1_px_reg;
    logic signed [sqvt_pkg::COORD_W-1:0]  p1_py_reg;

    logic                                 hold_adv;
    logic                                 s_xfer;
    logic signed [sqvt_pkg::OFS_W-1:0]    ox_next;
    logic signed [sqvt_pkg::OFS_W-1:0]    oy_next;
    logic signed [sqvt_pkg::TRIG_W-1:0]   cos_val;
    logic signed [sqvt_pkg::TRIG_W-1:0]   sin_val;

    assign hold_adv = en && hold_valid_reg;
    assign s_ready  = !hold_valid_reg || (hold_adv && (count_reg == LAST_CORNER));
    assign s_xfer   = s_valid && s_ready;

    always_comb begin
        ox_next = $signed({1'b0, base_x});
        oy_next = $signed({1'b0, base_y});
        if (count_reg[0]) begin
            ox_next = ox_next - $signed({1'b0, width, 16'd0});
        end
        if (count_reg[1]) begin
            oy_next = oy_next - $signed({1'b0, height, 16'd0});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            count_reg      <= '0;
            p1_valid_reg   <= 1'b0;
        end else begin
            if (en) begin
                p1_valid_reg <= hold_valid_reg;
            end
            if (s_xfer) begin
                hold_valid_reg <= 1'b1;
                count_reg      <= '0;
            end else if (hold_adv && (count_reg == LAST_CORNER)) begin
                hold_valid_reg <= 1'b0;
            end else if (hold_adv) begin
                count_reg <= count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            angle_reg <= s_angle;
            sx_reg    <= s_scale_x;
            sy_reg    <= s_scale_y;
            px_reg    <= s_position_x;
            py_reg    <= s_position_y;
        end
        if (en) begin
            p1_corner_reg <= count_reg;
            p1_last_reg   <= (count_reg == LAST_CORNER);
            p1_ox_reg     <= ox_next;
            p1_oy_reg     <= oy_next;
            p1_sx_reg     <= sx_reg;
            p1_sy_reg     <= sy_reg;
            p1_px_reg     <= px_reg;
            p1_py_reg     <= py_reg;
        end
    end

    sqvt_sine_rom #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_rom (
        .aclk    (aclk),
        .en      (en),
        .angle   (angle_reg),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    assign p1_valid = p1_valid_reg;

    always_comb begin
        p1_data.corner  = p1_corner_reg;
        p1_data.last    = p1_last_reg;
        p1_data.cos_val = cos_val;
        p1_data.sin_val = sin_val;
        p1_data.ofs_x   = p1_ox_reg;
        p1_data.ofs_y   = p1_oy_reg;
        p1_data.scale_x = p1_sx_reg;
        p1_data.scale_y = p1_sy_reg;
        p1_data.pos_x   = p1_px_reg;
        p1_data.pos_y   = p1_py_reg;
    end

endmodule

FILE: hdl/sqvt_datapath.sv
// Rotate, scale, round, translate and saturate pipeline for one corner per cycle while en is high.
module sqvt_datapath #(
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 p1_valid,
    input  sqvt_pkg::corner_t                    p1_data,
    output logic                                 out_valid,
    output logic [1:0]                           out_corner,
    output logic                                 out_last,
    output logic signed [sqvt_pkg::COORD_W-1:0]  out_x,
    output logic signed [sqvt_pkg::COORD_W-1:0]  out_y
);

    localparam int SHIFT = 39 - COORD_FRAC_BITS;
    localparam int LO_W  = 17 + sqvt_pkg::SPLIT_W + 1;
    localparam int HI_W  = 17 + sqvt_pkg::ROT_W - sqvt_pkg::SPLIT_W;
    localparam logic signed [sqvt_pkg::SUM_W-1:0] ROUND_HALF =
        64'sd1 <<< (SHIFT - 1);

    // stage 2: four trig products
    logic                                 p2_valid_reg;
    logic [1:0]                           p2_corner_reg;
    logic                                 p2_last_reg;
    logic signed [sqvt_pkg::ROT_W-1:0]    p2_cox_reg;
    logic signed [sqvt_pkg::ROT_W-1:0]    p2_soy_reg;
    logic signed [sqvt_pkg::ROT_W-1:0]    p2_sox_reg;
    logic signed [sqvt_pkg::ROT_W-1:0]    p2_coy_reg;
    logic [sqvt_pkg::SCALE_W-1:0]         p2_sx_reg;
    logic [sqvt_pkg::SCALE_W-1:0]         p2_sy_reg;
    logic signed [sqvt_pkg::COORD_W-1:0]  p2_px_reg;
    logic signed [sqvt_pkg::COORD_W-1:0]  p2_py_reg;

    // stage 3: rotated offsets
    logic                                 p3_valid_reg;
    logic [1:0]                           p3_corner_reg;
    logic                                 p3_last_reg;
    logic signed [sqvt_pkg::ROT_W-1:0]    p3_rx_reg;
    logic signed [sqvt_pkg::ROT_W-1:0]    p3_ry_reg;
    logic [sqvt_pkg::SCALE_W-1:0]         p3_sx_reg;
    logic [sqvt_pkg::SCALE_W-1:0]         p3_sy_reg;
    logic signed [sqvt_pkg::COORD_W-1:0]  p3_px_reg;
    logic signed [sqvt_pkg::COORD_W-1:0]  p3_py_reg;

    // stage 4: scale partial products
    logic                                 p4_valid_reg;
    logic [1:0]                           p4_corner_reg;
    logic                                 p4_last_reg;
    logic signed [LO_W-1:0]               p4_xlo_reg;
    logic signed [HI_W-1:0]               p4_xhi_reg;
    logic signed [LO_W-1:0]               p4_ylo_reg;
    logic signed [HI_W-1:0]               p4_yhi_reg;
    logic signed [sqvt_pkg::COORD_W-1:0]  p4_px_reg;
    logic signed [sqvt_pkg::COORD_W-1:0]  p4_py_reg;

    // stage 5: rounded and shifted
    logic                                 p5_valid_reg;
    logic [1:0]                           p5_corner_reg;
    logic                                 p5_last_reg;
    logic signed [sqvt_pkg::SHR_W-1:0]    p5_x_reg;
    logic signed [sqvt_pkg::SHR_W-1:0]    p5_y_reg;
    logic signed [sqvt_pkg::COORD_W-1:0]  p5_px_reg;
    logic signed [sqvt_pkg::COORD_W-1:0]  p5_py_reg;

    // stage 6: output register
    logic                                 p6_valid_reg;
    logic [1:0]                           p6_corner_reg;
    logic                                 p6_last_reg;
    logic signed [sqvt_pkg::COORD_W-1:0]  p6_x_reg;
    logic signed [sqvt_pkg::COORD_W-1:0]  p6_y_reg;

    logic signed [sqvt_pkg::SUM_W-1:0]    sum_x;
    logic signed [sqvt_pkg::SUM_W-1:0]    sum_y;
    logic signed [sqvt_pkg::SHR_W-1:0]    x5_next;
    logic signed [sqvt_pkg::SHR_W-1:0]    y5_next;
    logic signed [sqvt_pkg::VSUM_W-1:0]   vx;
    logic signed [sqvt_pkg::VSUM_W-1:0]   vy;
    logic signed [sqvt_pkg::COORD_W-1:0]  x6_next;
    logic signed [sqvt_pkg::COORD_W-1:0]  y6_next;

    always_comb begin
        sum_x = (sqvt_pkg::SUM_W'(p4_xhi_reg) <<< sqvt_pkg::SPLIT_W)
              + sqvt_pkg::SUM_W'(p4_xlo_reg) + ROUND_HALF;
        sum_y = (sqvt_pkg::SUM_W'(p4_yhi_reg) <<< sqvt_pkg::SPLIT_W)
              + sqvt_pkg::SUM_W'(p4_ylo_reg) + ROUND_HALF;
        x5_next = sqvt_pkg::SHR_W'(sum_x >>> SHIFT);
        y5_next = sqvt_pkg::SHR_W'(sum_y >>> SHIFT);
    end

    always_comb begin
        vx = sqvt_pkg::VSUM_W'(p5_x_reg) + sqvt_pkg::VSUM_W'(p5_px_reg);
        vy = sqvt_pkg::VSUM_W'(p5_y_reg) + sqvt_pkg::VSUM_W'(p5_py_reg);
        priority if (vx > sqvt_pkg::COORD_MAX) begin
            x6_next = sqvt_pkg::COORD_MAX[sqvt_pkg::COORD_W-1:0];
        end else if (vx < sqvt_pkg::COORD_MIN) begin
            x6_next = sqvt_pkg::COORD_MIN[sqvt_pkg::COORD_W-1:0];
        end else begin
            x6_next = vx[sqvt_pkg::COORD_W-1:0];
        end
        priority if (vy > sqvt_pkg::COORD_MAX) begin
            y6_next = sqvt_pkg::COORD_MAX[sqvt_pkg::COORD_W-1:0];
        end else if (vy < sqvt_pkg::COORD_MIN) begin
            y6_next = sqvt_pkg::COORD_MIN[sqvt_pkg::COORD_W-1:0];
        end else begin
            y6_next = vy[sqvt_pkg::COORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
            p6_valid_reg <= 1'b0;
        end else if (en) begin
            p2_valid_reg <= p1_valid;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            p5_valid_reg <= p4_valid_reg;
            p6_valid_reg <= p5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_corner_reg <= p1_data.corner;
            p2_last_reg   <= p1_data.last;
            p2_cox_reg    <= sqvt_pkg::ROT_W'(p1_data.cos_val)
                           * sqvt_pkg::ROT_W'(p1_data.ofs_x);
            p2_soy_reg    <= sqvt_pkg::ROT_W'(p1_data.sin_val)
                           * sqvt_pkg::ROT_W'(p1_data.ofs_y);
            p2_sox_reg    <= sqvt_pkg::ROT_W'(p1_data.sin_val)
                           * sqvt_pkg::ROT_W'(p1_data.ofs_x);
            p2_coy_reg    <= sqvt_pkg::ROT_W'(p1_data.cos_val)
                           * sqvt_pkg::ROT_W'(p1_data.ofs_y);
            p2_sx_reg     <= p1_data.scale_x;
            p2_sy_reg     <= p1_data.scale_y;
            p2_px_reg     <= p1_data.pos_x;
            p2_py_reg     <= p1_data.pos_y;

            p3_corner_reg <= p2_corner_reg;
            p3_last_reg   <= p2_last_reg;
            p3_rx_reg     <= p2_cox_reg - p2_soy_reg;
            p3_ry_reg     <= p2_sox_reg + p2_coy_reg;
            p3_sx_reg     <= p2_sx_reg;
            p3_sy_reg     <= p2_sy_reg;
            p3_px_reg     <= p2_px_reg;
            p3_py_reg     <= p2_py_reg;

            // split the scale multiply into a low unsigned and a high signed slice
            p4_corner_reg <= p3_corner_reg;
            p4_last_reg   <= p3_last_reg;
            p4_xlo_reg    <= LO_W'($signed({1'b0, p3_sx_reg}))
                           * LO_W'($signed({1'b0, p3_rx_reg[sqvt_pkg::SPLIT_W-1:0]}));
            p4_xhi_reg    <= HI_W'($signed({1'b0, p3_sx_reg}))
                           * HI_W'($signed(p3_rx_reg[sqvt_pkg::ROT_W-1:sqvt_pkg::SPLIT_W]));
            p4_ylo_reg    <= LO_W'($signed({1'b0, p3_sy_reg}))
                           * LO_W'($signed({1'b0, p3_ry_reg[sqvt_pkg::SPLIT_W-1:0]}));
            p4_yhi_reg    <= HI_W'($signed({1'b0, p3_sy_reg}))
                           * HI_W'($signed(p3_ry_reg[sqvt_pkg::ROT_W-1:sqvt_pkg::SPLIT_W]));
            p4_px_reg     <= p3_px_reg;
            p4_py_reg     <= p3_py_reg;

            p5_corner_reg <= p4_corner_reg;
            p5_last_reg   <= p4_last_reg;
            p5_x_reg      <= x5_next;
            p5_y_reg      <= y5_next;
            p5_px_reg     <= p4_px_reg;
            p5_py_reg     <= p4_py_reg;

            p6_corner_reg <= p5_corner_reg;
            p6_last_reg   <= p5_last_reg;
            p6_x_reg      <= x6_next;
            p6_y_reg      <= y6_next;
        end
    end

    assign out_valid  = p6_valid_reg;
    assign out_corner = p6_corner_reg;
    assign out_last   = p6_last_reg;
    assign out_x      = p6_x_reg;
    assign out_y      = p6_y_reg;

endmodule

FILE: hdl/sprite_quad_vertex_transform_core.sv
// Sprite quad vertex transform: each corner passes the issue registers and sine lookup, then the
// datapath registers. The corner sequencer issues one corner per cycle while the pipeline advances,
// and takes the next sprite with the last corner; one result channel carries all four corners.
// All stages advance together whenever the output register is empty or being taken.
// aresetn is synchronous, active low: it clears all valid bits and the sequencer and
// restores the registers (size 0 x 0, pivot 0.5 / 0.5). The sine table is constant.
module sprite_quad_vertex_transform_core #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int COORD_FRAC_BITS  = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [2:0]                           cfg_index,
    input  logic [sqvt_pkg::PIVOT_W-1:0]         cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [sqvt_pkg::ANGLE_W-1:0]         s_angle,
    input  logic [sqvt_pkg::SCALE_W-1:0]         s_scale_x,
    input  logic [sqvt_pkg::SCALE_W-1:0]         s_scale_y,
    input  logic signed [sqvt_pkg::COORD_W-1:0]  s_position_x,
    input  logic signed [sqvt_pkg::COORD_W-1:0]  s_position_y,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_corner_index,
    output logic signed [sqvt_pkg::COORD_W-1:0]  m_vertex_x,
    output logic signed [sqvt_pkg::COORD_W-1:0]  m_vertex_y,
    output logic                                 m_last
);

    localparam logic [2:0] REG_SPRITE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SPRITE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_PIVOT_X       = 3'd2;
    localparam logic [2:0] REG_PIVOT_Y       = 3'd3;

    logic [sqvt_pkg::DIM_W-1:0]    width_reg;
    logic [sqvt_pkg::DIM_W-1:0]    height_reg;
    logic [sqvt_pkg::PIVOT_W-1:0]  pivot_x_reg;
    logic [sqvt_pkg::PIVOT_W-1:0]  pivot_y_reg;
    logic [sqvt_pkg::BASE_W-1:0]   base_x_reg;
    logic [sqvt_pkg::BASE_W-1:0]   base_y_reg;

    logic [sqvt_pkg::PIVOT_W-1:0]  pvx;
    logic [sqvt_pkg::PIVOT_W-1:0]  pvy_comp;
    logic [sqvt_pkg::BASE_W:0]     base_x_next;
    logic [sqvt_pkg::BASE_W:0]     base_y_next;

    logic                          en;
    logic                          p1_valid;
    sqvt_pkg::corner_t             p1_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= '0;
            height_reg  <= '0;
            pivot_x_reg <= 17'd32768;
            pivot_y_reg <= 17'd32768;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SPRITE_WIDTH:  width_reg   <= cfg_data[sqvt_pkg::DIM_W-1:0];
                REG_SPRITE_HEIGHT: height_reg  <= cfg_data[sqvt_pkg::DIM_W-1:0];
                REG_PIVOT_X:       pivot_x_reg <= cfg_data;
                REG_PIVOT_Y:       pivot_y_reg <= cfg_data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // Corner-0 offsets are registered from the size and pivot registers; pivots above 1.0 clamp to 1.0.
    always_comb begin
        pvx      = (pivot_x_reg > sqvt_pkg::PIVOT_ONE) ? sqvt_pkg::PIVOT_ONE : pivot_x_reg;
        pvy_comp = sqvt_pkg::PIVOT_ONE
                 - ((pivot_y_reg > sqvt_pkg::PIVOT_ONE) ? sqvt_pkg::PIVOT_ONE : pivot_y_reg);
        base_x_next = (sqvt_pkg::BASE_W+1)'(width_reg) * (sqvt_pkg::BASE_W+1)'(pvx);
        base_y_next = (sqvt_pkg::BASE_W+1)'(height_reg) * (sqvt_pkg::BASE_W+1)'(pvy_comp);
    end

    always_ff @(posedge aclk) begin
        base_x_reg <= base_x_next[sqvt_pkg::BASE_W-1:0];
        base_y_reg <= base_y_next[sqvt_pkg::BASE_W-1:0];
    end

    // advance the whole pipeline when the output register can take a new corner
    assign en = !m_valid || m_ready;

    sqvt_issue #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_issue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_angle      (s_angle),
        .s_scale_x    (s_scale_x),
        .s_scale_y    (s_scale_y),
        .s_position_x (s_position_x),
        .s_position_y (s_position_y),
        .width        (width_reg),
        .height       (height_reg),
        .base_x       (base_x_reg),
        .base_y       (base_y_reg),
        .p1_valid     (p1_valid),
        .p1_data      (p1_data)
    );

    sqvt_datapath #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .p1_valid   (p1_valid),
        .p1_data    (p1_data),
        .out_valid  (m_valid),
        .out_corner (m_corner_index),
        .out_last   (m_last),
        .out_x      (m_vertex_x),
        .out_y      (m_vertex_y)
    );

endmodule
